[rtl/eafd_pkg.sv]
package eafd_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int IDX_W    = LEN_W + 1;
	localparam int PHASE_W  = 2;
	localparam int CFG_AW   = 8;
	localparam int CFG_DW   = 16;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 48;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
	localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;
	localparam logic [BYTE_W-1:0] SUM_GOOD   = 8'hFF;

	// index of the first payload byte (delimiter 0, length 1..2)
	localparam logic [IDX_W-1:0] PAYLOAD_IDX = 17'd3;

	localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
	localparam logic [PHASE_W-1:0] PH_LENH = 2'd1;
	localparam logic [PHASE_W-1:0] PH_LENL = 2'd2;
	localparam logic [PHASE_W-1:0] PH_BODY = 2'd3;

	localparam logic [CFG_AW-1:0] REG_SAMPLE_TYPE   = 8'd0;
	localparam logic [CFG_AW-1:0] REG_SAMPLE_OFFSET = 8'd1;

	localparam logic [BYTE_W-1:0] RST_SAMPLE_TYPE   = 8'd146;
	localparam logic [LEN_W-1:0]  RST_SAMPLE_OFFSET = 16'd20;

	typedef struct packed {
		logic [BYTE_W-1:0] sample_type;
		logic [LEN_W-1:0]  sample_offset;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0]  sample_value;
		logic              sample_valid;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] frame_type;
		logic              checksum_good;
	} result_t;

endpackage

[rtl/eafd_cfg_regs.sv]
module eafd_cfg_regs
	import eafd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CFG_AW-1:0] wr_addr,
	input  logic [CFG_DW-1:0] wr_data,
	output cfg_t              cfg
);

	logic [BYTE_W-1:0] sample_type_q;
	logic [LEN_W-1:0]  sample_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_type_q   <= RST_SAMPLE_TYPE;
			sample_offset_q <= RST_SAMPLE_OFFSET;
		end else if (wr_en) begin
			unique case (wr_addr)
				REG_SAMPLE_TYPE:   sample_type_q   <= wr_data[BYTE_W-1:0];
				REG_SAMPLE_OFFSET: sample_offset_q <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sample_type   = sample_type_q;
	assign cfg.sample_offset = sample_offset_q;

endmodule

[rtl/eafd_in_stage.sv]
module eafd_in_stage
	import eafd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	logic              vld_s1;
	logic [BYTE_W-1:0] dat_s1;

	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dat_s1 <= in_byte;
		end
	end

	assign valid_s1 = vld_s1;
	assign byte_s1  = dat_s1;

endmodule

[rtl/eafd_parser.sv]
module eafd_parser
	import eafd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] raw_byte,
	input  logic              take,
	input  cfg_t              cfg,
	output logic              emit,
	output result_t           res
);

	logic [PHASE_W-1:0] phase_q, phase_n;
	logic               esc_q, esc_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [IDX_W-1:0]   idx_q, idx_n;
	logic [BYTE_W-1:0]  sum_q, sum_n;
	logic [BYTE_W-1:0]  type_q, type_n;
	logic [BYTE_W-1:0]  hi_q, hi_n;
	logic [BYTE_W-1:0]  lo_q, lo_n;

	logic [BYTE_W-1:0] b;
	logic              escaped;
	logic              data_ok;
	logic              frame_end;
	logic [IDX_W-1:0]  off_hi;
	logic [IDX_W-1:0]  off_lo;
	logic [IDX_W-1:0]  last_idx;
	logic              hit_hi;
	logic              hit_lo;
	logic              good;
	logic              fits;
	logic              valid;

	assign off_hi   = {1'b0, cfg.sample_offset};
	assign off_lo   = off_hi + 17'd1;
	assign last_idx = {1'b0, len_q} + PAYLOAD_IDX;
	assign hit_hi   = (idx_q == off_hi);
	assign hit_lo   = (idx_q == off_lo);

	always_comb begin
		phase_n   = phase_q;
		esc_n     = esc_q;
		len_n     = len_q;
		idx_n     = idx_q;
		sum_n     = sum_q;
		type_n    = type_q;
		hi_n      = hi_q;
		lo_n      = lo_q;
		b         = raw_byte;
		escaped   = 1'b0;
		data_ok   = 1'b0;
		frame_end = 1'b0;

		if (esc_q) begin
			esc_n   = 1'b0;
			b       = raw_byte ^ ESC_XOR;
			escaped = 1'b1;
			data_ok = 1'b1;
		end else if (raw_byte == ESC_BYTE) begin
			esc_n = 1'b1;
		end else begin
			data_ok = 1'b1;
		end

		if (data_ok) begin
			unique case (phase_q)
				PH_HUNT: begin
					// index is zero while hunting, so the hit tests see the delimiter
					if (!escaped && b == START_BYTE) begin
						sum_n   = '0;
						type_n  = '0;
						hi_n    = hit_hi ? b : '0;
						lo_n    = hit_lo ? b : '0;
						len_n   = '0;
						idx_n   = 17'd1;
						phase_n = PH_LENH;
					end
				end
				PH_LENH: begin
					if (hit_hi) hi_n = b;
					if (hit_lo) lo_n = b;
					len_n   = {b, 8'h00};
					idx_n   = 17'd2;
					phase_n = PH_LENL;
				end
				PH_LENL: begin
					if (hit_hi) hi_n = b;
					if (hit_lo) lo_n = b;
					len_n   = {len_q[LEN_W-1:BYTE_W], b};
					idx_n   = PAYLOAD_IDX;
					phase_n = PH_BODY;
				end
				PH_BODY: begin
					if (hit_hi) hi_n = b;
					if (hit_lo) lo_n = b;
					sum_n = sum_q + b;
					if (idx_q == PAYLOAD_IDX && len_q != '0) type_n = b;
					if (idx_q < last_idx) begin
						idx_n = idx_q + 17'd1;
					end else begin
						// checksum byte closes the frame
						frame_end = 1'b1;
						idx_n     = '0;
						phase_n   = PH_HUNT;
					end
				end
				default: phase_n = PH_HUNT;
			endcase
		end
	end

	assign good  = (sum_n == SUM_GOOD);
	assign fits  = (off_lo <= last_idx);
	assign valid = good && fits && (type_n == cfg.sample_type);

	assign emit               = in_valid && frame_end;
	assign res.checksum_good  = good;
	assign res.frame_type     = type_n;
	assign res.payload_length = len_q;
	assign res.sample_valid   = valid;
	assign res.sample_value   = valid ? {hi_n, lo_n} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			esc_q   <= 1'b0;
			len_q   <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			type_q  <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			esc_q   <= esc_n;
			len_q   <= len_n;
			idx_q   <= idx_n;
			sum_q   <= sum_n;
			type_q  <= type_n;
			hi_q    <= hi_n;
			lo_q    <= lo_n;
		end
	end

`ifndef SYNTHESIS
	a_body_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (idx_q >= PAYLOAD_IDX && idx_q <= last_idx))
		else $error("byte index outside frame body");

	a_hunt_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> idx_q == '0)
		else $error("byte index not cleared while hunting");

	a_emit_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && take) |=> phase_q == PH_HUNT)
		else $error("frame end did not return to hunt");

	a_valid_needs_good: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!res.sample_valid || res.checksum_good))
		else $error("sample flagged valid on bad checksum");
`endif

endmodule

[rtl/eafd_out_stage.sv]
module eafd_out_stage
	import eafd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  result_t          res,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic             vld_q;
	logic [OUT_W-1:0] data_q;

	// full and not drained this cycle
	assign busy = vld_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {6'b0, res.sample_value, res.sample_valid, res.payload_length,
				res.frame_type, res.checksum_good};
		end
	end

	assign out_valid = vld_q;
	assign out_data  = data_q;

endmodule

[rtl/escaped_api_frame_deframer_unit.sv]
// Escaped API frame deframer: takes one raw serial byte per beat, strips 0x7D escapes
// (an escape may span any gap between beats), hunts for an unescaped 0x7E start byte,
// reads the 16-bit big-endian length, and after the checksum byte emits one result beat
// per frame with checksum status, frame type, length and the 16-bit sample found at the
// configured frame offset. Bad frames are reported, not dropped. A byte is taken every
// cycle, except that a frame-closing beat waits in the input register while the output
// register still holds an unaccepted result; each beat is held in the input register, and
// when a frame-closing beat moves on, its result is loaded into the output register. The
// per-byte state update between those two registers sets the one-byte-per-cycle rate.
// Register 0 holds the sample frame type, register 1 the sample offset; write them only
// while no frame data is in flight.
module escaped_api_frame_deframer_unit
	import eafd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [0] checksum_good, [8:1] frame_type,
	                                     // [24:9] payload_length, [25] sample_valid,
	                                     // [41:26] sample_value, [47:42] zero
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data
);

	cfg_t              cfg;
	result_t           res;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              emit;
	logic              out_busy;
	logic              advance;

	assign cfg_ready = 1'b1;

	// a beat that closes no frame moves on even when the output is full
	assign advance = valid_s1 && !(emit && out_busy);

	eafd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	eafd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata[BYTE_W-1:0]),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	eafd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.raw_byte (byte_s1),
		.take     (advance),
		.cfg      (cfg),
		.emit     (emit),
		.res      (res)
	);

	eafd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.res       (res),
		.busy      (out_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
